/* src/bdpc_pkg.sv */
// shared widths, register indexes, state codes and result struct for the press classifier
package bdpc_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned StateW = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegFilterMs = 2'd0;
  localparam logic [CfgIdxW-1:0] RegConfirmMs = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLongPressMs = 2'd2;

  // configuration reset values
  localparam logic [CfgW-1:0] FilterMsRst = 16'd30;
  localparam logic [CfgW-1:0] ConfirmMsRst = 16'd30;
  localparam logic [CfgW-1:0] LongPressMsRst = 16'd2000;

  // press state codes seen on the result port
  localparam logic [StateW-1:0] PsIdle = 3'd0;
  localparam logic [StateW-1:0] PsLong = 3'd3;

  // classifier result for one beat
  typedef struct packed {
    logic [StateW-1:0] press_state;
    logic              short_press;
    logic              long_press;
    logic              busy;
    logic              long_held;
  } cls_res_t;

endpackage

/* src/bdpc_filter.sv */
// sliding-window debounce filter with raw activity detect
module bdpc_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [bdpc_pkg::TimeW-1:0]    now_ms_i,
  input  logic                          raw_i,
  input  logic [bdpc_pkg::CfgW-1:0]     filter_ms_i,
  output logic                          filtered_o,
  output logic                          activity_o
);

  logic                       prev_raw_q, prev_raw_d;
  logic                       win_level_q, win_level_d;
  logic [bdpc_pkg::TimeW-1:0] win_start_q, win_start_d;
  logic                       filtered_q, filtered_d;
  logic [bdpc_pkg::TimeW-1:0] held;

  // window restarts on any change of the tracked level
  always_comb begin
    activity_o  = (raw_i != prev_raw_q);
    prev_raw_d  = raw_i;
    win_level_d = raw_i;
    win_start_d = (raw_i != win_level_q) ? now_ms_i : win_start_q;
    held        = now_ms_i - win_start_d;
    filtered_d  = (held >= {{(bdpc_pkg::TimeW-bdpc_pkg::CfgW){1'b0}}, filter_ms_i})
                  ? raw_i : filtered_q;
    filtered_o  = filtered_d;
  end

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_raw_q  <= 1'b0;
      win_level_q <= 1'b0;
      win_start_q <= '0;
      filtered_q  <= 1'b0;
    end else if (en_i) begin
      prev_raw_q  <= prev_raw_d;
      win_level_q <= win_level_d;
      win_start_q <= win_start_d;
      filtered_q  <= filtered_d;
    end
  end

endmodule

/* src/bdpc_fsm.sv */
// five-state press classifier driven by the debounced level
module bdpc_fsm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [bdpc_pkg::TimeW-1:0]    now_ms_i,
  input  logic                          filtered_i,
  input  logic [bdpc_pkg::CfgW-1:0]     confirm_ms_i,
  input  logic [bdpc_pkg::CfgW-1:0]     long_press_ms_i,
  output bdpc_pkg::cls_res_t            res_o
);

  typedef enum logic [bdpc_pkg::StateW-1:0] {
    StIdle    = 3'd0,
    StPConf   = 3'd1,
    StPressed = 3'd2,
    StLong    = 3'd3,
    StRConf   = 3'd4
  } state_e;

  state_e                     state_q, state_d;
  logic [bdpc_pkg::TimeW-1:0] timer_q, timer_d;
  logic                       from_long_q, from_long_d;
  logic                       busy_q, busy_d;
  logic                       long_flag_q, long_flag_d;
  logic                       sp, lp;
  logic [bdpc_pkg::TimeW-1:0] elapsed;
  logic                       confirm_done, long_done;

  // elapsed time in the current state, modulo 2^32
  assign elapsed = now_ms_i - timer_q;
  assign confirm_done =
    (elapsed >= {{(bdpc_pkg::TimeW-bdpc_pkg::CfgW){1'b0}}, confirm_ms_i});
  assign long_done =
    (elapsed >= {{(bdpc_pkg::TimeW-bdpc_pkg::CfgW){1'b0}}, long_press_ms_i});

  // next state and pulses
  always_comb begin
    state_d     = state_q;
    timer_d     = timer_q;
    from_long_d = from_long_q;
    busy_d      = busy_q;
    long_flag_d = long_flag_q;
    sp          = 1'b0;
    lp          = 1'b0;
    unique case (state_q)
      StPConf: begin
        if (!filtered_i) begin
          state_d = StIdle;
          busy_d  = 1'b0;
        end else if (confirm_done) begin
          timer_d = now_ms_i;
          state_d = StPressed;
        end
      end
      StPressed: begin
        if (!filtered_i) begin
          timer_d = now_ms_i;
          state_d = StRConf;
        end else if (long_done) begin
          timer_d     = now_ms_i;
          from_long_d = 1'b1;
          state_d     = StLong;
          long_flag_d = 1'b1;
          lp          = 1'b1;
        end
      end
      StLong: begin
        if (!filtered_i) begin
          timer_d = now_ms_i;
          state_d = StRConf;
        end
      end
      StRConf: begin
        // bounce during release goes back without reloading the timer
        if (filtered_i) begin
          state_d = from_long_q ? StLong : StPressed;
        end else if (confirm_done) begin
          sp          = !from_long_q;
          from_long_d = 1'b0;
          state_d     = StIdle;
          busy_d      = 1'b0;
          long_flag_d = 1'b0;
        end
      end
      default: begin
        if (filtered_i) begin
          timer_d = now_ms_i;
          state_d = StPConf;
          busy_d  = 1'b1;
        end else begin
          state_d = StIdle;
        end
      end
    endcase
  end

  // classifier state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      timer_q     <= '0;
      from_long_q <= 1'b0;
      busy_q      <= 1'b0;
      long_flag_q <= 1'b0;
    end else if (en_i) begin
      state_q     <= state_d;
      timer_q     <= timer_d;
      from_long_q <= from_long_d;
      busy_q      <= busy_d;
      long_flag_q <= long_flag_d;
    end
  end

  // result of this beat
  always_comb begin
    res_o.press_state = state_d;
    res_o.short_press = sp;
    res_o.long_press  = lp;
    res_o.busy        = busy_d;
    res_o.long_held   = long_flag_d;
  end

endmodule

/* src/button_debounce_press_classifier.sv */
// button debounce and short/long press classifier, top level
// pipeline: input beat to result beat through the input register and the result register
// throughput: one sample per cycle while the result side is not stalled; the filter and
// classifier update in one pass between the input register and the result register
// reset: filter and classifier state clear to idle/released, config regs take defaults
module button_debounce_press_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [bdpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bdpc_pkg::CfgW-1:0]     cfg_data_i,
  // sample channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bdpc_pkg::TimeW-1:0]    now_ms_i,
  input  logic                          raw_pressed_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          debounced_level_o,
  output logic [bdpc_pkg::StateW-1:0]   press_state_o,
  output logic                          short_press_o,
  output logic                          long_press_o,
  output logic                          busy_res_o,
  output logic                          long_held_o,
  output logic                          activity_o
);

  logic [bdpc_pkg::CfgW-1:0]  filter_ms_q, confirm_ms_q, long_press_ms_q;
  logic                       in_valid_q;
  logic [bdpc_pkg::TimeW-1:0] now_q;
  logic                       raw_q;
  logic                       out_valid_q;
  logic                       out_free, step;
  logic                       filtered, act;
  bdpc_pkg::cls_res_t         cls;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_ms_q     <= bdpc_pkg::FilterMsRst;
      confirm_ms_q    <= bdpc_pkg::ConfirmMsRst;
      long_press_ms_q <= bdpc_pkg::LongPressMsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bdpc_pkg::RegFilterMs:    filter_ms_q     <= cfg_data_i;
        bdpc_pkg::RegConfirmMs:   confirm_ms_q    <= cfg_data_i;
        bdpc_pkg::RegLongPressMs: long_press_ms_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake: a beat moves from the input register when the result slot is free
  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      now_q <= now_ms_i;
      raw_q <= raw_pressed_i;
    end
  end

  bdpc_filter u_filter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (step),
    .now_ms_i    (now_q),
    .raw_i       (raw_q),
    .filter_ms_i (filter_ms_q),
    .filtered_o  (filtered),
    .activity_o  (act)
  );

  bdpc_fsm u_fsm (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (step),
    .now_ms_i        (now_q),
    .filtered_i      (filtered),
    .confirm_ms_i    (confirm_ms_q),
    .long_press_ms_i (long_press_ms_q),
    .res_o           (cls)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      debounced_level_o <= filtered;
      press_state_o     <= cls.press_state;
      short_press_o     <= cls.short_press;
      long_press_o      <= cls.long_press;
      busy_res_o        <= cls.busy;
      long_held_o       <= cls.long_held;
      activity_o        <= act;
    end
  end

  assign out_valid_o = out_valid_q;

  // short and long pulses never share a beat
  a_pulse_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(short_press_o && long_press_o))
    else $error("short and long press in the same beat");

  // busy exactly while the classifier is away from idle
  a_busy_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (busy_res_o == (press_state_o != bdpc_pkg::PsIdle)))
    else $error("busy flag out of step with press state");

  // long pulse lands in the long state with the held flag set
  a_long_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && long_press_o) |-> (press_state_o == bdpc_pkg::PsLong && long_held_o))
    else $error("long press pulse outside the long state");

  // a beat in the input register that cannot move holds the input side stalled
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while the pipeline is full");

endmodule

/* tb/press_classifier_checker.sv */
// result checker for the press classifier: predicts every result beat and compares it
module press_classifier_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bdpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bdpc_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [bdpc_pkg::TimeW-1:0]    now_ms_i,
  input  logic                          raw_pressed_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic                          debounced_level_i,
  input  logic [bdpc_pkg::StateW-1:0]   press_state_i,
  input  logic                          short_press_i,
  input  logic                          long_press_i,
  input  logic                          busy_res_i,
  input  logic                          long_held_i,
  input  logic                          activity_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            checked_o
);
  import bdpc_pkg::*;

  // gesture states not named in the package
  localparam logic [StateW-1:0] StPressConfirm   = 3'd1;
  localparam logic [StateW-1:0] StPressed        = 3'd2;
  localparam logic [StateW-1:0] StReleaseConfirm = 3'd4;

  typedef struct packed {
    logic              deb;
    logic [StateW-1:0] state;
    logic              short_press;
    logic              long_press;
    logic              busy;
    logic              long_held;
    logic              activity;
  } press_result_t;

  // register copies
  logic [CfgW-1:0]   filter_time;
  logic [CfgW-1:0]   confirm_time;
  logic [CfgW-1:0]   long_time;

  // filter and gesture state
  logic              last_raw;
  logic              win_level;
  logic [TimeW-1:0]  win_start;
  logic              deb_level;
  logic [StateW-1:0] gesture_state;
  logic [TimeW-1:0]  state_mark;
  logic              was_long;
  logic              busy_q;
  logic              long_q;

  press_result_t     predicted_q[$];
  press_result_t     want;
  press_result_t     got;

  // one sample through the filter and the gesture machine
  function automatic press_result_t classify_sample(input logic [TimeW-1:0] t,
                                                    input logic raw);
    press_result_t    r;
    logic [TimeW-1:0] since_edge;
    logic [TimeW-1:0] in_state;
    r = '0;
    r.activity = (raw != last_raw);
    last_raw = raw;
    if (raw != win_level) begin
      win_start = t;
      win_level = raw;
    end
    since_edge = t - win_start;
    if (since_edge >= filter_time) deb_level = raw;
    in_state = t - state_mark;
    case (gesture_state)
      StPressConfirm: begin
        if (!deb_level) begin
          gesture_state = PsIdle;
          busy_q = 1'b0;
        end else if (in_state >= confirm_time) begin
          state_mark = t;
          gesture_state = StPressed;
        end
      end
      StPressed: begin
        if (!deb_level) begin
          state_mark = t;
          gesture_state = StReleaseConfirm;
        end else if (in_state >= long_time) begin
          state_mark = t;
          was_long = 1'b1;
          gesture_state = PsLong;
          long_q = 1'b1;
          r.long_press = 1'b1;
        end
      end
      PsLong: begin
        if (!deb_level) begin
          state_mark = t;
          gesture_state = StReleaseConfirm;
        end
      end
      StReleaseConfirm: begin
        // bounce back keeps the timer as it is
        if (deb_level) begin
          gesture_state = was_long ? PsLong : StPressed;
        end else if (in_state >= confirm_time) begin
          r.short_press = !was_long;
          was_long = 1'b0;
          gesture_state = PsIdle;
          busy_q = 1'b0;
          long_q = 1'b0;
        end
      end
      default: begin
        if (deb_level) begin
          state_mark = t;
          gesture_state = StPressConfirm;
          busy_q = 1'b1;
        end else begin
          gesture_state = PsIdle;
        end
      end
    endcase
    r.deb = deb_level;
    r.state = gesture_state;
    r.busy = busy_q;
    r.long_held = long_q;
    return r;
  endfunction

  assign got = '{deb: debounced_level_i, state: press_state_i, short_press: short_press_i,
                 long_press: long_press_i, busy: busy_res_i, long_held: long_held_i,
                 activity: activity_i};

  // track register writes, predict on input beats, compare on result beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_time = FilterMsRst;
      confirm_time = ConfirmMsRst;
      long_time = LongPressMsRst;
      last_raw = 1'b0;
      win_level = 1'b0;
      win_start = '0;
      deb_level = 1'b0;
      gesture_state = PsIdle;
      state_mark = '0;
      was_long = 1'b0;
      busy_q = 1'b0;
      long_q = 1'b0;
      predicted_q.delete();
      fail_count_o = 0;
      pending_o = 0;
      checked_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        checked_o++;
        if (predicted_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: result beat with no sample waiting: deb=%b st=%0d sp=%b lp=%b",
                     $time, got.deb, got.state, got.short_press, got.long_press);
        end else begin
          want = predicted_q.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("%0t: result %0d differs", $time, checked_o);
              $display("  want deb=%b st=%0d sp=%b lp=%b busy=%b held=%b act=%b",
                       want.deb, want.state, want.short_press, want.long_press,
                       want.busy, want.long_held, want.activity);
              $display("  got  deb=%b st=%0d sp=%b lp=%b busy=%b held=%b act=%b",
                       got.deb, got.state, got.short_press, got.long_press,
                       got.busy, got.long_held, got.activity);
            end
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegFilterMs:    filter_time = cfg_data_i;
          RegConfirmMs:   confirm_time = cfg_data_i;
          RegLongPressMs: long_time = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        predicted_q.push_back(classify_sample(now_ms_i, raw_pressed_i));
      pending_o = predicted_q.size();
    end
  end

endmodule

/* tb/tb_button_debounce_press_classifier.sv */
// testbench top for the press classifier: stimulus, idling, register settings and verdict
module tb_button_debounce_press_classifier;
  import bdpc_pkg::*;

  localparam int Latency    = 2;
  localparam int CycleLimit = 600000;
  localparam int PhaseItems = 204;
  localparam int NumPhases  = 8;

  // write to an index with no register behind it
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgW-1:0]    cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [TimeW-1:0]   now_ms = '0;
  logic               raw_pressed = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               debounced_level;
  logic [StateW-1:0]  press_state;
  logic               short_press;
  logic               long_press;
  logic               busy_res;
  logic               long_held;
  logic               activity;

  int                 fail_count;
  int                 pending;
  int                 checked;
  int                 cycle_count = 0;
  int                 sample_count = 0;
  int unsigned        gap_pct = 0;
  int unsigned        stall_pct = 0;
  int unsigned        stall_left = 0;
  logic [TimeW-1:0]   now_t = '0;

  always #5 clk = ~clk;

  button_debounce_press_classifier i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .now_ms_i         (now_ms),
    .raw_pressed_i    (raw_pressed),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .debounced_level_o(debounced_level),
    .press_state_o    (press_state),
    .short_press_o    (short_press),
    .long_press_o     (long_press),
    .busy_res_o       (busy_res),
    .long_held_o      (long_held),
    .activity_o       (activity)
  );

  press_classifier_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .now_ms_i         (now_ms),
    .raw_pressed_i    (raw_pressed),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .debounced_level_i(debounced_level),
    .press_state_i    (press_state),
    .short_press_i    (short_press),
    .long_press_i     (long_press),
    .busy_res_i       (busy_res),
    .long_held_i      (long_held),
    .activity_i       (activity),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("button_debounce_press_classifier: mismatch");
      $finish;
    end
  end

  // result side back-pressure in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(0, 8);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // one sample beat, entered and left at a falling edge
  task automatic send_sample(input logic [TimeW-1:0] t, input logic raw);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid <= 1'b1;
    now_ms <= t;
    raw_pressed <= raw;
    do @(posedge clk); while (!in_ready);
    sample_count++;
    @(negedge clk);
  endtask

  // stop sending and let every predicted result come out
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (Latency + 2) @(negedge clk);
  endtask

  task automatic program_regs(input logic [CfgW-1:0] f, input logic [CfgW-1:0] c,
                              input logic [CfgW-1:0] l, input bit poke_spare);
    cfg_we <= 1'b1;
    cfg_idx <= RegFilterMs;
    cfg_data <= f;
    @(negedge clk);
    cfg_idx <= RegConfirmMs;
    cfg_data <= c;
    @(negedge clk);
    cfg_idx <= RegLongPressMs;
    cfg_data <= l;
    @(negedge clk);
    if (poke_spare) begin
      cfg_idx <= RegSpare;
      cfg_data <= CfgW'($urandom);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // mostly short times, now and then anything in the register range
  function automatic logic [CfgW-1:0] pick_time();
    if ($urandom_range(3) == 0) return CfgW'($urandom_range(0, 65535));
    return CfgW'($urandom_range(0, 40));
  endfunction

  // time step between samples, with rare jumps anywhere on the clock
  function automatic logic [TimeW-1:0] next_step(input int unsigned scale);
    if ($urandom_range(49) == 0) return $urandom;
    return $urandom_range(0, scale);
  endfunction

  // press and release runs with bounce, plus some raw noise
  task automatic run_gestures(input int unsigned n_items, input int unsigned scale,
                              input bit hold_midway);
    int unsigned sent;
    int unsigned run_len;
    bit          level;
    bit          held;
    sent = 0;
    level = 1'b0;
    held = 1'b0;
    while (sent < n_items) begin
      if (hold_midway && !held && sent >= n_items / 2) begin
        drain_results();
        held = 1'b1;
      end
      if ($urandom_range(99) < 85) begin
        level = !level;
        run_len = $urandom_range(1, 24);
        repeat (run_len) begin
          now_t = now_t + next_step(scale);
          send_sample(now_t, ($urandom_range(11) == 0) ? !level : level);
          sent++;
        end
      end else begin
        run_len = $urandom_range(1, 8);
        repeat (run_len) begin
          now_t = now_t + next_step(scale);
          send_sample(now_t, 1'($urandom_range(1)));
          sent++;
        end
      end
    end
  endtask

  initial begin
    logic [CfgW-1:0] f;
    logic [CfgW-1:0] c;
    logic [CfgW-1:0] l;
    int unsigned     scale;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // default times: long press with a bounce in release confirm, then a short press
    gap_pct = 20;
    stall_pct = 20;
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b1);
    send_sample(32'h0000_001D, 1'b1);
    send_sample(32'h0000_003B, 1'b1);
    send_sample(32'h0000_0040, 1'b0);
    send_sample(32'h0000_0041, 1'b1);
    send_sample(32'h0000_0810, 1'b1);
    send_sample(32'h0000_0900, 1'b1);
    send_sample(32'h0000_0901, 1'b0);
    send_sample(32'h0000_0920, 1'b0);
    send_sample(32'h0000_0930, 1'b1);
    send_sample(32'h0000_0950, 1'b1);
    send_sample(32'h0000_0960, 1'b0);
    send_sample(32'h0000_0990, 1'b0);
    send_sample(32'h0000_09AE, 1'b0);
    send_sample(32'h7FFF_FFF0, 1'b1);
    send_sample(32'h8000_000E, 1'b1);
    send_sample(32'h8000_002C, 1'b1);
    send_sample(32'h8000_0030, 1'b0);
    send_sample(32'h8000_004E, 1'b0);
    send_sample(32'h8000_006C, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    drain_results();

    // random phases, each under its own register setting
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin
          f = '0;
          c = '0;
          l = '0;
        end
        1: begin
          f = '0;
          c = '0;
          l = 16'd1;
        end
        2: begin
          f = '1;
          c = '1;
          l = '1;
        end
        default: begin
          f = pick_time();
          c = pick_time();
          l = pick_time();
        end
      endcase
      program_regs(f, c, l, p == 0);
      if (p == NumPhases - 1 || p % 3 == 1) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = $urandom_range(10, 40);
        stall_pct = $urandom_range(10, 40);
      end
      scale = (int'(f) + int'(c) + int'(l)) / 8 + 1;
      now_t = $urandom;
      run_gestures(PhaseItems, scale, p == 3 || p == 5);
      drain_results();
    end

    repeat (Latency + 8) @(negedge clk);
    $display("covered %0d samples over %0d register settings plus defaults, %0d results compared",
             sample_count, NumPhases, checked);
    $display("settings included zero times, all-ones times and a write to the spare index");
    if (fail_count == 0 && pending == 0) begin
      $display("button_debounce_press_classifier: match");
    end else begin
      $display("button_debounce_press_classifier: mismatch");
    end
    $finish;
  end

endmodule

/* button_debounce_press_classifier.f */
src/bdpc_pkg.sv
src/bdpc_filter.sv
src/bdpc_fsm.sv
src/button_debounce_press_classifier.sv
tb/press_classifier_checker.sv
tb/tb_button_debounce_press_classifier.sv
